// ===== design/bgd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_pkg: shared types and constants of the button gesture detector
// Request payloads, configuration set, event codes and the structs
// that pass between the sequencer, the repeat divider and the output queue.
// ----------------------------------------------------------------------------
package bgd_pkg;

    // input request: poll time stamp and raw level
    typedef struct packed {
        logic [31:0] now_ms;
        logic        raw_pressed;
    } t_in;

    // output request: one gesture event
    typedef struct packed {
        logic [3:0] event_code;
        logic       last;
    } t_out;

    // configuration register set
    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] long_long_press_ms;
        logic [15:0] repeat_base_ms;
        logic [15:0] double_click_ms;
        logic        long_long_enable;
        logic        paused;
    } t_cfg;

    // register indexes
    localparam logic [2:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [2:0] CFG_LONG       = 3'd1;
    localparam logic [2:0] CFG_LONG_LONG  = 3'd2;
    localparam logic [2:0] CFG_REP_BASE   = 3'd3;
    localparam logic [2:0] CFG_DBL_CLICK  = 3'd4;
    localparam logic [2:0] CFG_LL_ENABLE  = 3'd5;
    localparam logic [2:0] CFG_PAUSED     = 3'd6;

    // register reset values
    localparam logic [15:0] RST_DEBOUNCE  = 16'd20;
    localparam logic [15:0] RST_LONG      = 16'd1000;
    localparam logic [15:0] RST_LONG_LONG = 16'd3000;
    localparam logic [15:0] RST_REP_BASE  = 16'd200;
    localparam logic [15:0] RST_DBL_CLICK = 16'd300;

    // event codes
    localparam logic [3:0] EV_PRESSED      = 4'd0;
    localparam logic [3:0] EV_PRESSING     = 4'd1;
    localparam logic [3:0] EV_LONG         = 4'd2;
    localparam logic [3:0] EV_LONG_REPEAT  = 4'd3;
    localparam logic [3:0] EV_LONG_END     = 4'd4;
    localparam logic [3:0] EV_LONGLONG     = 4'd5;
    localparam logic [3:0] EV_LONGLONG_END = 4'd6;
    localparam logic [3:0] EV_CLICKED      = 4'd7;
    localparam logic [3:0] EV_RELEASED     = 4'd8;
    localparam logic [3:0] EV_SHORT_CLICK  = 4'd9;
    localparam logic [3:0] EV_DOUBLE_CLICK = 4'd10;

    // repeat period curve: base + NUM / (OFFSET + SCALE * count), floor FLOOR
    localparam int DIV_W  = 23;   // divisor bits, holds OFFSET + SCALE * 65535
    localparam int NUM_W  = 18;   // dividend bits
    localparam int QUO_W  = 8;    // quotient never exceeds NUM / OFFSET
    localparam int PER_W  = 17;   // base + quotient
    localparam logic [NUM_W-1:0] REPEAT_NUM    = 18'd150000;
    localparam logic [DIV_W-1:0] REPEAT_OFFSET = 23'd1000;
    localparam logic [DIV_W-1:0] REPEAT_SCALE  = 23'd80;
    localparam logic [PER_W-1:0] REPEAT_FLOOR  = 17'd50;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

    // event push into the output queue
    typedef struct packed {
        logic valid;
        t_out data;
    } t_push;

endpackage

// ===== design/bgd_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_divider: serial restoring divider for the repeat period
// Divides the fixed repeat numerator by the requested divisor, one quotient
// bit per cycle, and pulses done with the quotient.
// ----------------------------------------------------------------------------
module bgd_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bgd_pkg::t_div_req  i_req,
    output bgd_pkg::t_div_rsp  o_rsp
);

    localparam int DW = bgd_pkg::DIV_W;
    localparam int NW = bgd_pkg::NUM_W;
    localparam logic [4:0] LAST_STEP = 5'(NW - 1);

    logic          r_busy;
    logic          r_done;
    logic [4:0]    r_step;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_div;

    logic [DW:0]   trial;
    logic          fits;
    logic [DW:0]   diff;

    // one trial subtraction per cycle
    always_comb begin
        trial = {r_rem, r_quo[NW-1]};
        fits  = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= bgd_pkg::REPEAT_NUM;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= fits ? diff[DW-1:0] : trial[DW-1:0];
                r_quo  <= {r_quo[NW-2:0], fits};
                r_step <= r_step + 5'd1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[bgd_pkg::QUO_W-1:0];

endmodule

// ===== design/bgd_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_out_queue: two-entry event queue on the output channel
// Holds the events of one poll so the sequencer can take the next poll
// while the consumer stalls.
// ----------------------------------------------------------------------------
module bgd_out_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bgd_pkg::t_push  i_push,
    output logic            o_space,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bgd_pkg::t_out   o_out_data
);

    bgd_pkg::t_out r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    logic pop;

    // a push still in flight from the sequencer already holds a slot
    assign pop         = o_out_valid && i_out_ready;
    assign o_space     = (r_cnt == 2'd0) || (r_cnt == 2'd1 && !i_push.valid);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            unique case ({i_push.valid, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/bgd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_core: poll sequencer, debounce and gesture state machine
// Takes one poll, debounces it, steps the gesture machine, runs the repeat
// divider when a long-press repeat fires and pushes the events in order.
// ----------------------------------------------------------------------------
module bgd_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bgd_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bgd_pkg::t_in       i_in_data,
    input  logic               i_space,
    output bgd_pkg::t_push     o_push,
    output bgd_pkg::t_div_req  o_div_req,
    input  bgd_pkg::t_div_rsp  i_div_rsp
);

    localparam int PW = bgd_pkg::PER_W;
    localparam int DW = bgd_pkg::DIV_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEB,
        S_GEST,
        S_DIVSET,
        S_DIVWAIT,
        S_EMIT0,
        S_EMIT1
    } t_seq;

    typedef enum logic [2:0] {
        G_IDLE,
        G_PRESS,
        G_LONG,
        G_RELEASE,
        G_LONGLONG
    } t_gest;

    t_seq          r_state;
    t_gest         r_gst;
    logic [31:0]   r_now;
    logic          r_level;
    logic          r_stable;
    logic [31:0]   r_deb_start;
    logic [31:0]   r_prev;
    logic [31:0]   r_elapsed;
    logic [31:0]   r_hold;
    logic [31:0]   r_long_hold;
    logic [31:0]   r_click;
    logic [31:0]   r_prev_click;
    logic [15:0]   r_count;
    logic [PW-1:0] r_period;
    logic [3:0]    r_ev0;
    logic [3:0]    r_ev1;
    logic          r_two;
    logic          r_div_start;
    logic [DW-1:0] r_divisor;

    logic [31:0]   deb_diff;
    logic [31:0]   hold_sum;
    logic [31:0]   long_sum;
    logic [PW-1:0] limit;
    logic [31:0]   click_gap;
    logic [PW-1:0] rep_sum;

    // datapath helpers
    always_comb begin
        deb_diff   = r_now - r_deb_start;
        hold_sum   = r_hold + r_elapsed;
        long_sum   = r_long_hold + r_elapsed;
        limit      = (r_period == '0) ? {1'b0, i_cfg.repeat_base_ms} : r_period;
        click_gap  = r_click - r_prev_click;
        rep_sum    = {1'b0, i_cfg.repeat_base_ms}
                   + {{(PW - bgd_pkg::QUO_W){1'b0}}, i_div_rsp.quotient};
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_div_req.start   = r_div_start;
    assign o_div_req.divisor = r_divisor;

    // sequencer, gesture state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gst        <= G_IDLE;
            r_stable     <= 1'b0;
            r_deb_start  <= '0;
            r_prev       <= '0;
            r_hold       <= '0;
            r_long_hold  <= '0;
            r_click      <= '0;
            r_prev_click <= '0;
            r_count      <= '0;
            r_period     <= {1'b0, bgd_pkg::RST_REP_BASE};
            r_div_start  <= 1'b0;
            o_push       <= '0;
        end else begin
            r_div_start  <= 1'b0;
            o_push.valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !i_cfg.paused) begin
                        r_now   <= i_in_data.now_ms;
                        r_level <= i_in_data.raw_pressed;
                        r_state <= S_DEB;
                    end
                end
                // debounce; a pending change ends the poll here
                S_DEB: begin
                    r_elapsed <= r_now - r_prev;
                    r_prev    <= r_now;
                    r_state   <= S_GEST;
                    if (r_level != r_stable) begin
                        if (r_deb_start == '0) begin
                            r_deb_start <= r_now;
                        end else if (deb_diff >= {16'd0, i_cfg.debounce_ms}) begin
                            r_deb_start <= '0;
                            r_stable    <= r_level;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_deb_start <= '0;
                    end
                end
                S_GEST: begin
                    r_state <= S_EMIT0;
                    r_two   <= 1'b0;
                    unique case (r_gst)
                        G_IDLE: begin
                            if (r_stable) begin
                                r_gst <= G_PRESS;
                                r_ev0 <= bgd_pkg::EV_PRESSED;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        G_PRESS: begin
                            if (!r_stable) begin
                                r_gst        <= G_RELEASE;
                                r_hold       <= '0;
                                r_prev_click <= r_click;
                                r_click      <= r_now;
                                r_ev0        <= bgd_pkg::EV_CLICKED;
                                r_ev1        <= bgd_pkg::EV_RELEASED;
                                r_two        <= 1'b1;
                            end else if (hold_sum >= {16'd0, i_cfg.long_press_ms}) begin
                                r_gst       <= G_LONG;
                                r_long_hold <= hold_sum;
                                r_hold      <= '0;
                                r_ev0       <= bgd_pkg::EV_LONG;
                            end else begin
                                r_hold <= hold_sum;
                                r_ev0  <= bgd_pkg::EV_PRESSING;
                            end
                        end
                        G_LONG: begin
                            if (r_stable) begin
                                r_hold      <= hold_sum;
                                r_long_hold <= long_sum;
                                if (i_cfg.long_long_enable
                                    && long_sum >= {16'd0, i_cfg.long_long_press_ms}) begin
                                    r_gst       <= G_LONGLONG;
                                    r_long_hold <= '0;
                                    r_ev0       <= bgd_pkg::EV_LONGLONG;
                                end else if (hold_sum >= {15'd0, limit}) begin
                                    // repeat fires: bump count, then divide
                                    r_hold <= '0;
                                    if (r_count != 16'hFFFF) begin
                                        r_count <= r_count + 16'd1;
                                    end
                                    r_state <= S_DIVSET;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end else begin
                                r_gst    <= G_IDLE;
                                r_hold   <= '0;
                                r_count  <= '0;
                                r_period <= {1'b0, i_cfg.repeat_base_ms};
                                r_ev0    <= bgd_pkg::EV_CLICKED;
                                r_ev1    <= bgd_pkg::EV_LONG_END;
                                r_two    <= 1'b1;
                            end
                        end
                        G_RELEASE: begin
                            if (r_stable) begin
                                r_gst <= G_PRESS;
                                r_ev0 <= bgd_pkg::EV_PRESSED;
                            end else begin
                                r_gst <= G_IDLE;
                                r_ev0 <= (click_gap < {16'd0, i_cfg.double_click_ms})
                                       ? bgd_pkg::EV_DOUBLE_CLICK
                                       : bgd_pkg::EV_SHORT_CLICK;
                            end
                        end
                        G_LONGLONG: begin
                            if (!r_stable) begin
                                r_gst  <= G_IDLE;
                                r_hold <= '0;
                                r_ev0  <= bgd_pkg::EV_LONGLONG_END;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        default: begin
                            r_gst   <= G_IDLE;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                // divisor of the repeat curve from the updated count
                S_DIVSET: begin
                    r_divisor   <= bgd_pkg::REPEAT_OFFSET
                                 + DW'(r_count) * bgd_pkg::REPEAT_SCALE;
                    r_div_start <= 1'b1;
                    r_state     <= S_DIVWAIT;
                end
                S_DIVWAIT: begin
                    if (i_div_rsp.done) begin
                        r_period <= (rep_sum < bgd_pkg::REPEAT_FLOOR)
                                  ? bgd_pkg::REPEAT_FLOOR : rep_sum;
                        r_ev0    <= bgd_pkg::EV_LONG_REPEAT;
                        r_state  <= S_EMIT0;
                    end
                end
                S_EMIT0: begin
                    if (i_space) begin
                        o_push.valid           <= 1'b1;
                        o_push.data.event_code <= r_ev0;
                        o_push.data.last       <= !r_two;
                        r_state                <= r_two ? S_EMIT1 : S_IDLE;
                    end
                end
                S_EMIT1: begin
                    if (i_space) begin
                        o_push.valid           <= 1'b1;
                        o_push.data.event_code <= r_ev1;
                        o_push.data.last       <= 1'b1;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a paused poll leaves the sequencer idle
    a_paused_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_cfg.paused) |=> (r_state == S_IDLE))
        else $error("paused poll started the sequencer");

    // divider answers only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == S_DIVWAIT))
        else $error("divider done outside of wait state");

    // repeat count only steps up by one or clears
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 16'd1 || r_count == '0))
        else $error("repeat count jumped");

    // a pushed repeat event finds the repeat period at or above its floor
    a_repeat_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && o_push.data.event_code == bgd_pkg::EV_LONG_REPEAT)
        |-> (r_period >= bgd_pkg::REPEAT_FLOOR))
        else $error("repeat period below floor");

endmodule

// ===== design/button_gesture_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector: debounced button click and long-press detector
// Channel   | direction | payload                         | handshake
// poll      | in        | now_ms[31:0], raw_pressed       | i_in_valid / o_in_ready
// event     | out       | event_code[3:0], last           | o_out_valid / i_out_ready
// config    | in        | index[2:0], data[15:0]          | i_cfg_valid / o_cfg_ready
//
// A poll ends at once when paused, after the debounce step if debounce holds it back,
// after the gesture step if it yields no event, else after pushing its one or two events;
// a long-press repeat also waits on the serial divider (load plus 18 bits).
// Reset is synchronous, active low; registers return to their defaults.
// Up to two events of a poll wait in the output queue; a stalled consumer
// blocks the sequencer only when the queue lacks room for the next event.
// ----------------------------------------------------------------------------
module button_gesture_detector (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bgd_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bgd_pkg::t_out   o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data
);

    bgd_pkg::t_cfg     r_cfg;
    bgd_pkg::t_push    push;
    bgd_pkg::t_div_req div_req;
    bgd_pkg::t_div_rsp div_rsp;
    logic              space;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= bgd_pkg::RST_DEBOUNCE;
            r_cfg.long_press_ms      <= bgd_pkg::RST_LONG;
            r_cfg.long_long_press_ms <= bgd_pkg::RST_LONG_LONG;
            r_cfg.repeat_base_ms     <= bgd_pkg::RST_REP_BASE;
            r_cfg.double_click_ms    <= bgd_pkg::RST_DBL_CLICK;
            r_cfg.long_long_enable   <= 1'b0;
            r_cfg.paused             <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bgd_pkg::CFG_DEBOUNCE:  r_cfg.debounce_ms        <= i_cfg_data;
                bgd_pkg::CFG_LONG:      r_cfg.long_press_ms      <= i_cfg_data;
                bgd_pkg::CFG_LONG_LONG: r_cfg.long_long_press_ms <= i_cfg_data;
                bgd_pkg::CFG_REP_BASE:  r_cfg.repeat_base_ms     <= i_cfg_data;
                bgd_pkg::CFG_DBL_CLICK: r_cfg.double_click_ms    <= i_cfg_data;
                bgd_pkg::CFG_LL_ENABLE: r_cfg.long_long_enable   <= i_cfg_data[0];
                bgd_pkg::CFG_PAUSED:    r_cfg.paused             <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bgd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_space    (space),
        .o_push     (push),
        .o_div_req  (div_req),
        .i_div_rsp  (div_rsp)
    );

    bgd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    bgd_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== bench/bgd_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_event_checker: gesture event predictor and scoreboard
// Watches the poll, event and register channels of the button gesture
// detector, predicts the events of every accepted poll from its own copy of
// the registers and gesture state, and compares them in order with the events
// the block hands out. Reports failures, outstanding events and events seen.
// ----------------------------------------------------------------------------
module bgd_event_checker
    import bgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // repeat period curve
    localparam logic [31:0] REP_NUM    = 32'd150000;
    localparam logic [31:0] REP_OFFSET = 32'd1000;
    localparam logic [31:0] REP_SCALE  = 32'd80;
    localparam logic [31:0] REP_FLOOR  = 32'd50;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        GS_IDLE,
        GS_PRESS,
        GS_LONG,
        GS_RELEASE,
        GS_LONGLONG
    } t_gesture;

    // register copy and gesture state
    t_cfg        regs;
    t_gesture    gesture;
    logic        stable;
    logic [31:0] deb_start;
    logic [31:0] last_poll;
    logic [31:0] hold_ms;
    logic [31:0] long_hold_ms;
    logic [31:0] click_at;
    logic [31:0] prev_click_at;
    logic [15:0] rep_count;
    logic [31:0] rep_period;

    t_out gesture_events [$];   // expected, oldest first
    t_out poll_events [$];      // events of the poll being predicted
    t_out want;
    int   fails;
    int   checked;

    task automatic add_event(input logic [3:0] code);
        poll_events.push_back('{event_code: code, last: 1'b0});
    endtask

    // next state and events of one poll
    task automatic predict_poll(input t_in poll);
        logic [31:0] elapsed;
        logic [31:0] limit;
        logic [31:0] period;
        if (regs.paused)
            return;
        poll_events.delete();
        elapsed   = poll.now_ms - last_poll;
        last_poll = poll.now_ms;

        // debounce: a change waits until it has lasted debounce_ms
        if (poll.raw_pressed != stable) begin
            if (deb_start == 32'd0) begin
                deb_start = poll.now_ms;
            end else if (poll.now_ms - deb_start >= {16'd0, regs.debounce_ms}) begin
                deb_start = 32'd0;
                stable    = poll.raw_pressed;
            end else begin
                return;
            end
        end else begin
            deb_start = 32'd0;
        end

        case (gesture)
            GS_IDLE: begin
                if (stable) begin
                    gesture = GS_PRESS;
                    add_event(EV_PRESSED);
                end
            end
            GS_PRESS: begin
                if (!stable) begin
                    gesture       = GS_RELEASE;
                    hold_ms       = 32'd0;
                    prev_click_at = click_at;
                    click_at      = poll.now_ms;
                    add_event(EV_CLICKED);
                    add_event(EV_RELEASED);
                end else begin
                    hold_ms = hold_ms + elapsed;
                    if (hold_ms >= {16'd0, regs.long_press_ms}) begin
                        gesture      = GS_LONG;
                        long_hold_ms = hold_ms;
                        hold_ms      = 32'd0;
                        add_event(EV_LONG);
                    end else begin
                        add_event(EV_PRESSING);
                    end
                end
            end
            GS_LONG: begin
                if (stable) begin
                    hold_ms      = hold_ms + elapsed;
                    long_hold_ms = long_hold_ms + elapsed;
                    if (regs.long_long_enable &&
                        long_hold_ms >= {16'd0, regs.long_long_press_ms}) begin
                        gesture      = GS_LONGLONG;
                        long_hold_ms = 32'd0;
                        add_event(EV_LONGLONG);
                    end else begin
                        // repeats speed up with the count, floored
                        limit = (rep_period == 32'd0) ? {16'd0, regs.repeat_base_ms}
                                                      : rep_period;
                        if (hold_ms >= limit) begin
                            hold_ms = 32'd0;
                            if (rep_count != COUNT_MAX)
                                rep_count = rep_count + 16'd1;
                            period = {16'd0, regs.repeat_base_ms}
                                   + REP_NUM / (REP_OFFSET + {16'd0, rep_count} * REP_SCALE);
                            rep_period = (period < REP_FLOOR) ? REP_FLOOR : period;
                            add_event(EV_LONG_REPEAT);
                        end
                    end
                end else begin
                    gesture    = GS_IDLE;
                    hold_ms    = 32'd0;
                    rep_count  = 16'd0;
                    rep_period = {16'd0, regs.repeat_base_ms};
                    add_event(EV_CLICKED);
                    add_event(EV_LONG_END);
                end
            end
            GS_RELEASE: begin
                if (stable) begin
                    gesture = GS_PRESS;
                    add_event(EV_PRESSED);
                end else begin
                    gesture = GS_IDLE;
                    if (click_at - prev_click_at < {16'd0, regs.double_click_ms})
                        add_event(EV_DOUBLE_CLICK);
                    else
                        add_event(EV_SHORT_CLICK);
                end
            end
            GS_LONGLONG: begin
                if (!stable) begin
                    gesture = GS_IDLE;
                    hold_ms = 32'd0;
                    add_event(EV_LONGLONG_END);
                end
            end
            default: gesture = GS_IDLE;
        endcase

        if (poll_events.size() > 0)
            poll_events[poll_events.size() - 1].last = 1'b1;
        foreach (poll_events[k])
            gesture_events.push_back(poll_events[k]);
    endtask

    // compare first, then register writes, then new polls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs          = '{debounce_ms: RST_DEBOUNCE, long_press_ms: RST_LONG,
                              long_long_press_ms: RST_LONG_LONG,
                              repeat_base_ms: RST_REP_BASE,
                              double_click_ms: RST_DBL_CLICK,
                              long_long_enable: 1'b0, paused: 1'b0};
            gesture       = GS_IDLE;
            stable        = 1'b0;
            deb_start     = 32'd0;
            last_poll     = 32'd0;
            hold_ms       = 32'd0;
            long_hold_ms  = 32'd0;
            click_at      = 32'd0;
            prev_click_at = 32'd0;
            rep_count     = 16'd0;
            rep_period    = {16'd0, RST_REP_BASE};
            gesture_events.delete();
            fails         = 0;
            checked       = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (gesture_events.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected event: expected none, got code %0d last %0b",
                             $time, i_out_data.event_code, i_out_data.last);
                end else begin
                    want = gesture_events.pop_front();
                    checked++;
                    if (i_out_data.event_code !== want.event_code) begin
                        fails++;
                        $display("%0t: event code: expected %0d, got %0d",
                                 $time, want.event_code, i_out_data.event_code);
                    end
                    if (i_out_data.last !== want.last) begin
                        fails++;
                        $display("%0t: last flag (code %0d): expected %0b, got %0b",
                                 $time, want.event_code, want.last, i_out_data.last);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE:  regs.debounce_ms        = i_cfg_data;
                    CFG_LONG:      regs.long_press_ms      = i_cfg_data;
                    CFG_LONG_LONG: regs.long_long_press_ms = i_cfg_data;
                    CFG_REP_BASE:  regs.repeat_base_ms     = i_cfg_data;
                    CFG_DBL_CLICK: regs.double_click_ms    = i_cfg_data;
                    CFG_LL_ENABLE: regs.long_long_enable   = i_cfg_data[0];
                    CFG_PAUSED:    regs.paused             = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_poll(i_in_data);
        end
        o_pending    <= gesture_events.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: button gesture detector testbench
// Drives a directed run of poll requests at the reset settings, then phases
// of random press and release gestures with bounce and time jumps, each under
// its own register setting, extremes and a paused stretch among them. Both
// channels idle at random; the event checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import bgd_pkg::*;

    localparam int          CYCLE_LIMIT    = 1000000;
    localparam int          SETTLE_CYCLES  = 40;     // outlasts a long-press repeat poll
    localparam int          RX_HOLD_CYCLES = 400;
    localparam logic [2:0]  CFG_UNUSED     = 3'd7;   // beyond the register list
    localparam int          DIR_COUNT      = 25;
    localparam logic [0:DIR_COUNT-1] DIR_LEVEL = 25'b1111111_000_11_000_11_000_11_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in         in_data   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    t_out        o_out_data;
    logic        o_cfg_ready;
    int          chk_fails;
    int          chk_pending;
    int          chk_checked;

    logic [31:0] now_t;
    logic        lvl;
    bit          rx_hold_req   = 1'b0;
    int          tx_burst      = 0;
    int          polls_sent    = 0;
    int          setting_count = 0;
    int          cycle_count   = 0;

    button_gesture_detector uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bgd_event_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_checked    (chk_checked)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // wait before the next request; runs of back-to-back requests now and then
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic send_poll(input logic [31:0] stamp, input logic level);
        int gap;
        gap = draw_gap(tx_burst);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{now_ms: stamp, raw_pressed: level};
        do @(posedge clk); while (!(in_valid && o_in_ready));
        polls_sent++;
    endtask

    // leaves cfg_valid high; the caller lowers it
    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && o_cfg_ready));
    endtask

    // stop polling, wait for all events, then for the block to settle
    task automatic drain_events();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register setting, then random gestures with bounce and time jumps
    task automatic run_phase(input t_cfg setting, input int polls, input int step_max,
                             input int seg_max, input int noise_pct, input int first_hold);
        int          seg;
        int          left;
        logic [31:0] step;
        bit          bounce;
        drain_events();
        write_reg(CFG_DEBOUNCE,  setting.debounce_ms);
        write_reg(CFG_LONG,      setting.long_press_ms);
        write_reg(CFG_LONG_LONG, setting.long_long_press_ms);
        write_reg(CFG_REP_BASE,  setting.repeat_base_ms);
        write_reg(CFG_DBL_CLICK, setting.double_click_ms);
        write_reg(CFG_LL_ENABLE, {15'($urandom), setting.long_long_enable});
        write_reg(CFG_PAUSED,    {15'($urandom), setting.paused});
        write_reg(CFG_UNUSED,    16'($urandom));
        cfg_valid <= 1'b0;
        setting_count++;

        left = polls;
        while (left > 0) begin
            if (first_hold > 0) begin
                lvl        = 1'b1;
                seg        = first_hold;
                first_hold = 0;
            end else begin
                lvl = ~lvl;
                case ($urandom_range(0, 3))
                    0: seg = $urandom_range(1, 2);
                    1: seg = $urandom_range(2, 6);
                    default: seg = $urandom_range(1, seg_max);
                endcase
            end
            repeat (seg) begin
                if (left > 0) begin
                    if ($urandom_range(0, 79) == 0)
                        step = $urandom;
                    else
                        step = $urandom_range(1, step_max);
                    now_t  = now_t + step;
                    bounce = ($urandom_range(0, 99) < noise_pct);
                    send_poll(now_t, lvl ^ bounce);
                    left--;
                end
            end
        end
    endtask

    // event receiver: random stalls, one long hold-off on request
    initial begin
        int gap;
        int burst;
        burst = 0;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                gap = RX_HOLD_CYCLES;
            end else begin
                gap = draw_gap(burst);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(o_out_valid && out_ready));
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int unsigned dir_stamp [DIR_COUNT];
        t_cfg        mix;
        dir_stamp = '{0, 5, 10, 30, 500, 1600, 1900, 1901, 1925, 1930,
                      2000, 2030, 2040, 2070, 2080, 2090, 2110, 2120, 2150, 2160,
                      2200, 2230, 2240, 2700, 2710};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: change at time zero, debounce hold-back, press,
        // pressing, long, repeat, long end, click, short and double click
        foreach (dir_stamp[i])
            send_poll(dir_stamp[i], DIR_LEVEL[i]);
        now_t = dir_stamp[DIR_COUNT - 1];
        lvl   = 1'b0;

        // fields: debounce, long, long-long, repeat base, double click, ll enable, paused
        rx_hold_req = 1'b1;
        run_phase('{16'd3, 16'd40, 16'd100, 16'd8, 16'd60, 1'b1, 1'b0}, 300, 6, 25, 8, 0);
        run_phase('{16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 1'b1, 1'b0}, 200, 4, 10, 5, 0);
        now_t = 32'hFFFF_0000;
        run_phase('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0},
                  150, 40000, 8, 3, 0);
        run_phase('{16'd5, 16'd20, 16'd50, 16'd10, 16'd100, 1'b0, 1'b1}, 60, 30, 10, 10, 0);
        // one long hold with the repeat period falling to its floor
        run_phase('{16'd2, 16'd10, 16'hFFFF, 16'd1, 16'd30, 1'b0, 1'b0}, 400, 200, 30, 2, 300);
        rx_hold_req = 1'b1;
        run_phase('{16'd20, 16'd1000, 16'd3000, 16'd200, 16'd300, 1'b1, 1'b0},
                  400, 60, 80, 6, 0);
        mix.debounce_ms        = 16'($urandom_range(0, 30));
        mix.long_press_ms      = 16'($urandom_range(1, 400));
        mix.long_long_press_ms = 16'($urandom_range(1, 2000));
        mix.repeat_base_ms     = 16'($urandom_range(1, 300));
        mix.double_click_ms    = 16'($urandom_range(0, 500));
        mix.long_long_enable   = 1'($urandom);
        mix.paused             = 1'b0;
        run_phase(mix, 300, 40, 30, 8, 0);
        drain_events();

        $display("Covered %0d polls under %0d register settings, with a paused stretch,",
                 polls_sent, setting_count);
        $display("long event stalls and time wrap; %0d events compared.", chk_checked);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("No mismatches found");
        end else begin
            if (chk_pending != 0)
                $display("%0t: %0d predicted events never arrived", $time, chk_pending);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bgd_pkg.sv
design/bgd_divider.sv
design/bgd_out_queue.sv
design/bgd_core.sv
design/button_gesture_detector.sv
bench/bgd_event_checker.sv
bench/tb.sv
